>>> sv/cst_pkg.sv
package cst_pkg;

    localparam int TEXT_CAP = 256;
    localparam int TC_W     = $clog2(TEXT_CAP + 1);
    localparam int MAX_RES  = 8;
    localparam int IDX_W    = $clog2(MAX_RES);
    localparam int CNT_W    = $clog2(MAX_RES + 1);

    // source characters
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    // event codes
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_TEXT  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // token types
    localparam logic [2:0] TY_NEWLINE = 3'd0;
    localparam logic [2:0] TY_STRING  = 3'd1;
    localparam logic [2:0] TY_WORD    = 3'd2;
    localparam logic [2:0] TY_KEYVAL  = 3'd3;
    localparam logic [2:0] TY_EOI     = 3'd4;

    // byte roles
    localparam logic [1:0] RL_PLAIN = 2'd0;
    localparam logic [1:0] RL_KEY   = 2'd1;
    localparam logic [1:0] RL_SEP   = 2'd2;
    localparam logic [1:0] RL_VALUE = 2'd3;

    localparam logic [15:0] POS_ONE = 16'd1;
    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  ty;
        logic [7:0]  tb;
        logic [1:0]  role;
        logic [15:0] ln;
        logic [15:0] cl;
    } t_res;

    typedef struct packed {
        logic            seen;
        logic            key_nonempty;
        logic [TC_W-1:0] count;
        logic [1:0]      role;
        logic            emit;
    } t_wchar;

    function automatic t_res mk_res(logic [1:0] ev, logic [2:0] ty, logic [7:0] tb,
                                    logic [1:0] role, logic [15:0] ln, logic [15:0] cl);
        t_res r;
        r.ev   = ev;
        r.ty   = ty;
        r.tb   = tb;
        r.role = role;
        r.ln   = ln;
        r.cl   = cl;
        return r;
    endfunction

    // classify one word byte and update the key/value split and text count
    function automatic t_wchar word_char(logic seen, logic kn, logic [TC_W-1:0] count,
                                         logic [7:0] b);
        t_wchar w;
        w.seen         = seen;
        w.key_nonempty = kn;
        w.count        = count;
        if (seen) begin
            w.role = RL_VALUE;
        end else if (b == CH_EQUALS) begin
            w.seen         = 1'b1;
            w.key_nonempty = (count != '0);
            w.role         = RL_SEP;
        end else begin
            w.role = RL_KEY;
        end
        w.emit = (count < TC_W'(TEXT_CAP - 1));
        if (w.emit) w.count = count + TC_W'(1);
        return w;
    endfunction

    function automatic logic word_term(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT || b == CH_FF ||
               b == CH_CR || b == CH_HASH || b == CH_NUL;
    endfunction

endpackage

>>> sv/config_stream_tokenizer.sv
// Results of an accepted byte are registered and appear in the next cycle.
// Throughput: one byte per cycle while i_stall is low and each byte yields at most
//   one result; a byte with N results (up to 7) stalls input until all are taken.
// Reset (i_rst_n low, synchronous): idle between tokens, line and column at 1,
//   result buffer empty.
module config_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_res,
    output logic [2:0]  o_token_type,
    output logic [7:0]  o_text_byte,
    output logic [1:0]  o_role,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_col,
    output logic        o_last
);

    typedef enum logic [3:0] {
        M_IDLE, M_AFTER_CR, M_COMMENT, M_WORD, M_STRING, M_STRING_ESC,
        M_CONT_BARE, M_CONT_SPACED, M_CONT_CR, M_ERROR
    } t_mode;

    t_mode                     r_mode, n_mode;
    logic [15:0]               r_line, n_line, r_col, n_col;
    logic [15:0]               r_sline, n_sline, r_scol, n_scol;
    logic [15:0]               r_hline, n_hline, r_hcol, n_hcol;
    logic [cst_pkg::TC_W-1:0]  r_tc, n_tc;
    logic                      r_seen, n_seen, r_kn, n_kn;

    cst_pkg::t_res             r_buf [cst_pkg::MAX_RES];
    cst_pkg::t_res             n_buf [cst_pkg::MAX_RES];
    logic [cst_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [cst_pkg::IDX_W-1:0] r_idx;

    logic                      do_word, do_idle, frozen;
    cst_pkg::t_wchar           wc;
    logic                      in_xfer, out_xfer, cur_last;
    logic [7:0]                b;

    assign b        = i_data_byte;
    assign o_valid  = (r_cnt != '0);
    assign cur_last = ({1'b0, r_idx} == r_cnt - cst_pkg::CNT_W'(1));
    assign out_xfer = o_valid && !i_stall;
    assign o_stall  = o_valid && !(out_xfer && cur_last);
    assign in_xfer  = i_valid && !o_stall;

    assign o_event_res  = r_buf[r_idx].ev;
    assign o_token_type = r_buf[r_idx].ty;
    assign o_text_byte  = r_buf[r_idx].tb;
    assign o_role       = r_buf[r_idx].role;
    assign o_token_line = r_buf[r_idx].ln;
    assign o_token_col  = r_buf[r_idx].cl;
    assign o_last       = cur_last;

    // lex one item: next state plus the list of results it causes
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_hline = r_hline;
        n_hcol  = r_hcol;
        n_tc    = r_tc;
        n_seen  = r_seen;
        n_kn    = r_kn;
        n_cnt   = '0;
        for (int k = 0; k < cst_pkg::MAX_RES; k++) n_buf[k] = '0;
        do_word = 1'b0;
        do_idle = 1'b0;
        frozen  = 1'b0;
        wc      = '0;

        if (i_kind) begin
            // flush the open token, then the end-of-input token
            case (r_mode)
                M_WORD: begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                        (r_seen && r_kn) ? cst_pkg::TY_KEYVAL : cst_pkg::TY_WORD,
                        8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                    n_cnt = n_cnt + 1'b1;
                end
                M_STRING: begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                        cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                    n_cnt = n_cnt + 1'b1;
                end
                M_STRING_ESC: begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_ERROR,
                        cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                    n_cnt = n_cnt + 1'b1;
                end
                M_CONT_BARE, M_CONT_SPACED, M_CONT_CR: begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                        cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                    n_cnt = n_cnt + 1'b1;
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                        cst_pkg::TY_WORD, cst_pkg::CH_BSLASH, cst_pkg::RL_KEY, r_hline, r_hcol);
                    n_cnt = n_cnt + 1'b1;
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                        cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                    n_cnt = n_cnt + 1'b1;
                    if (r_mode == M_CONT_CR) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                            cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                            cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt = n_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
            n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                cst_pkg::TY_EOI, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
            n_cnt = n_cnt + 1'b1;
            n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                cst_pkg::TY_EOI, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
            n_cnt = n_cnt + 1'b1;
            n_mode  = M_IDLE;
            n_line  = cst_pkg::POS_ONE;
            n_col   = cst_pkg::POS_ONE;
            n_sline = cst_pkg::POS_ONE;
            n_scol  = cst_pkg::POS_ONE;
            n_hline = cst_pkg::POS_ONE;
            n_hcol  = cst_pkg::POS_ONE;
            n_tc    = '0;
            n_seen  = 1'b0;
            n_kn    = 1'b0;
        end else begin
            // first pass: the current mode
            case (r_mode)
                M_ERROR: frozen = 1'b1;
                M_AFTER_CR: begin
                    if (b == cst_pkg::CH_LF) n_mode = M_IDLE;
                    else do_idle = 1'b1;
                end
                M_COMMENT: begin
                    if (b == cst_pkg::CH_LF) do_idle = 1'b1;
                    else if (b == cst_pkg::CH_NUL) n_mode = M_IDLE;
                end
                M_WORD: do_word = 1'b1;
                M_STRING: begin
                    if (b == cst_pkg::CH_QUOTE) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                            cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = M_IDLE;
                    end else if (b == cst_pkg::CH_BSLASH) begin
                        n_mode = M_STRING_ESC;
                    end else if (b == cst_pkg::CH_LF || b == cst_pkg::CH_NUL) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_ERROR,
                            cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = M_ERROR;
                    end else if (r_tc < cst_pkg::TC_W'(cst_pkg::TEXT_CAP - 1)) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                            cst_pkg::TY_STRING, b, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt = n_cnt + 1'b1;
                        n_tc  = r_tc + cst_pkg::TC_W'(1);
                    end
                end
                M_STRING_ESC: begin
                    if (b == cst_pkg::CH_LF || b == cst_pkg::CH_NUL) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_ERROR,
                            cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt  = n_cnt + 1'b1;
                        n_mode = M_ERROR;
                    end else begin
                        if (r_tc < cst_pkg::TC_W'(cst_pkg::TEXT_CAP - 1)) begin
                            n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(
                                cst_pkg::EV_TEXT, cst_pkg::TY_STRING,
                                (b == cst_pkg::CH_LOW_N) ? cst_pkg::CH_LF :
                                (b == cst_pkg::CH_LOW_T) ? cst_pkg::CH_TAB :
                                (b == cst_pkg::CH_LOW_R) ? cst_pkg::CH_CR : b,
                                cst_pkg::RL_PLAIN, r_sline, r_scol);
                            n_cnt = n_cnt + 1'b1;
                            n_tc  = r_tc + cst_pkg::TC_W'(1);
                        end
                        n_mode = M_STRING;
                    end
                end
                M_CONT_BARE, M_CONT_SPACED: begin
                    if (b == cst_pkg::CH_SPACE || b == cst_pkg::CH_TAB) begin
                        n_mode = M_CONT_SPACED;
                    end else if (b == cst_pkg::CH_CR) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_mode  = M_CONT_CR;
                    end else if (b == cst_pkg::CH_LF) begin
                        n_mode = M_IDLE;
                    end else if (r_mode == M_CONT_BARE) begin
                        // failed join: the backslash opens a word that goes on
                        n_sline = r_hline;
                        n_scol  = r_hcol;
                        n_mode  = M_WORD;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                            cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        wc = cst_pkg::word_char(1'b0, 1'b0, '0, cst_pkg::CH_BSLASH);
                        if (wc.emit) begin
                            n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(
                                cst_pkg::EV_TEXT, cst_pkg::TY_WORD, cst_pkg::CH_BSLASH,
                                wc.role, r_hline, r_hcol);
                            n_cnt = n_cnt + 1'b1;
                        end
                        n_seen  = wc.seen;
                        n_kn    = wc.key_nonempty;
                        n_tc    = wc.count;
                        do_word = 1'b1;
                    end else begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                            cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                            cst_pkg::TY_WORD, cst_pkg::CH_BSLASH, cst_pkg::RL_KEY,
                            r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                            cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                        n_cnt   = n_cnt + 1'b1;
                        n_tc    = cst_pkg::TC_W'(1);
                        n_seen  = 1'b0;
                        n_kn    = 1'b0;
                        do_idle = 1'b1;
                    end
                end
                M_CONT_CR: begin
                    if (b == cst_pkg::CH_LF) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                            cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                            cst_pkg::TY_WORD, cst_pkg::CH_BSLASH, cst_pkg::RL_KEY,
                            r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                            cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_hline, r_hcol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                            cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt = n_cnt + 1'b1;
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                            cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_sline, r_scol);
                        n_cnt   = n_cnt + 1'b1;
                        n_tc    = cst_pkg::TC_W'(1);
                        n_seen  = 1'b0;
                        n_kn    = 1'b0;
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            // second pass: a byte inside a word
            if (do_word) begin
                if (cst_pkg::word_term(b)) begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                        (n_seen && n_kn) ? cst_pkg::TY_KEYVAL : cst_pkg::TY_WORD,
                        8'd0, cst_pkg::RL_PLAIN, n_sline, n_scol);
                    n_cnt   = n_cnt + 1'b1;
                    n_mode  = M_IDLE;
                    do_idle = 1'b1;
                end else begin
                    wc = cst_pkg::word_char(n_seen, n_kn, n_tc, b);
                    if (wc.emit) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                            cst_pkg::TY_WORD, b, wc.role, n_sline, n_scol);
                        n_cnt = n_cnt + 1'b1;
                    end
                    n_seen = wc.seen;
                    n_kn   = wc.key_nonempty;
                    n_tc   = wc.count;
                end
            end

            // third pass: a byte between tokens
            if (do_idle) begin
                n_mode = M_IDLE;
                if (b == cst_pkg::CH_SPACE || b == cst_pkg::CH_TAB || b == cst_pkg::CH_VT ||
                    b == cst_pkg::CH_FF || b == cst_pkg::CH_NUL) begin
                    n_mode = M_IDLE;
                end else if (b == cst_pkg::CH_BSLASH) begin
                    n_hline = r_line;
                    n_hcol  = r_col;
                    n_mode  = M_CONT_BARE;
                end else if (b == cst_pkg::CH_HASH) begin
                    n_mode = M_COMMENT;
                end else if (b == cst_pkg::CH_CR || b == cst_pkg::CH_LF) begin
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                        cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
                    n_cnt = n_cnt + 1'b1;
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_END,
                        cst_pkg::TY_NEWLINE, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
                    n_cnt = n_cnt + 1'b1;
                    if (b == cst_pkg::CH_CR) n_mode = M_AFTER_CR;
                end else if (b == cst_pkg::CH_QUOTE) begin
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_tc    = '0;
                    n_mode  = M_STRING;
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                        cst_pkg::TY_STRING, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
                    n_cnt = n_cnt + 1'b1;
                end else begin
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_mode  = M_WORD;
                    n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_START,
                        cst_pkg::TY_WORD, 8'd0, cst_pkg::RL_PLAIN, r_line, r_col);
                    n_cnt = n_cnt + 1'b1;
                    wc = cst_pkg::word_char(1'b0, 1'b0, '0, b);
                    if (wc.emit) begin
                        n_buf[n_cnt[cst_pkg::IDX_W-1:0]] = cst_pkg::mk_res(cst_pkg::EV_TEXT,
                            cst_pkg::TY_WORD, b, wc.role, r_line, r_col);
                        n_cnt = n_cnt + 1'b1;
                    end
                    n_seen = wc.seen;
                    n_kn   = wc.key_nonempty;
                    n_tc   = wc.count;
                end
            end

            // advance position, saturating
            if (!frozen) begin
                if (b == cst_pkg::CH_LF) begin
                    if (r_line != cst_pkg::POS_MAX) n_line = r_line + 16'd1;
                    n_col = cst_pkg::POS_ONE;
                end else if (r_col != cst_pkg::POS_MAX) begin
                    n_col = r_col + 16'd1;
                end
            end
        end
    end

    // hold lexer state and the result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= cst_pkg::POS_ONE;
            r_col   <= cst_pkg::POS_ONE;
            r_sline <= cst_pkg::POS_ONE;
            r_scol  <= cst_pkg::POS_ONE;
            r_hline <= cst_pkg::POS_ONE;
            r_hcol  <= cst_pkg::POS_ONE;
            r_tc    <= '0;
            r_seen  <= 1'b0;
            r_kn    <= 1'b0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else if (in_xfer) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_hline <= n_hline;
            r_hcol  <= n_hcol;
            r_tc    <= n_tc;
            r_seen  <= n_seen;
            r_kn    <= n_kn;
            r_cnt   <= n_cnt;
            r_idx   <= '0;
            r_buf   <= n_buf;
        end else if (out_xfer) begin
            if (cur_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("result index beyond buffered count");

    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while results are held");

    a_error_freezes_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_kind && r_mode == M_ERROR) |=> ($stable(r_line) && $stable(r_col)))
        else $error("position moved in error wait");

    a_eoi_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_kind) |=> (r_buf[r_cnt[cst_pkg::IDX_W-1:0] - 1'b1].ty
                                 == cst_pkg::TY_EOI))
        else $error("end marker batch not closed by end-of-input token");

endmodule
